// ===== rtl/ssv_pkg.sv =====
// Package for the shape side-from-volume block: field widths, shape codes
// and the exact rational shape constants k = num / den.
// No dependencies.
package ssv_pkg;

   localparam int OP_W = 2;
   localparam int VOL_W = 32;
   localparam int SIDE_W = 24;
   localparam int INT_BITS = 6;
   localparam int NUM_W = 31;
   localparam int DEN_W = 29;

   localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

   localparam logic [OP_W-1:0] OP_CUBE = 2'd0;
   localparam logic [OP_W-1:0] OP_SPHERE = 2'd1;
   localparam logic [OP_W-1:0] OP_CYLINDER = 2'd2;
   localparam logic [OP_W-1:0] OP_CONE = 2'd3;

   typedef logic [OP_W-1:0] op_type;

   // Numerator of k, with pi taken as 314159265 / 10^8.
   function automatic logic [NUM_W-1:0] shape_num(input op_type op);
      logic [NUM_W-1:0] num;
      case (op)
         OP_CUBE: num = 31'd1;
         OP_SPHERE: num = 31'd1256637060;
         OP_CYLINDER: num = 31'd314159265;
         OP_CONE: num = 31'd314159265;
         default: num = 31'd1;
      endcase
      return num;
   endfunction

   function automatic logic [DEN_W-1:0] shape_den(input op_type op);
      logic [DEN_W-1:0] den;
      case (op)
         OP_CUBE: den = 29'd1;
         OP_SPHERE: den = 29'd300000000;
         OP_CYLINDER: den = 29'd100000000;
         OP_CONE: den = 29'd300000000;
         default: den = 29'd1;
      endcase
      return den;
   endfunction

endpackage

// ===== rtl/ssv_if.sv =====
// Valid/ready channel interfaces for the request and response of the
// shape side-from-volume block. Depends on ssv_pkg.
interface ssv_req_if;
   logic valid;
   logic ready;
   logic [ssv_pkg::OP_W-1:0] operation;
   logic [ssv_pkg::VOL_W-1:0] volume;

   modport source (output valid, output operation, output volume, input ready);
   modport sink (input valid, input operation, input volume, output ready);
endinterface

interface ssv_rsp_if;
   logic valid;
   logic ready;
   logic [ssv_pkg::SIDE_W-1:0] side_length;

   modport source (output valid, output side_length, input ready);
   modport sink (input valid, input side_length, output ready);
endinterface

// ===== rtl/ssv_root_stage.sv =====
// One root bit of the cube-root recurrence, split over two register stages:
// the first forms the trial increment, the second compares and updates.
// Depends on ssv_pkg.
module ssv_root_stage #(
   parameter int BIT = 0,
   parameter int LW = 22,
   parameter int WIDE = 98
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [ssv_pkg::OP_W-1:0] in_op,
   input  logic [WIDE-1:0] in_rem,
   input  logic [WIDE-1:0] in_p1,
   input  logic [WIDE-1:0] in_p2,
   input  logic [LW-1:0] in_root,
   output logic out_valid,
   output logic [ssv_pkg::OP_W-1:0] out_op,
   output logic [WIDE-1:0] out_rem,
   output logic [WIDE-1:0] out_p1,
   output logic [WIDE-1:0] out_p2,
   output logic [LW-1:0] out_root
);
   import ssv_pkg::*;

   // rem = num * (volume * den * 2^s) / num - num * root^3, p1 = num * root,
   // p2 = num * root^2. Setting this bit of the root only needs shifts and adds.
   logic [WIDE-1:0] num_w;
   logic [WIDE-1:0] delta_in;
   logic [WIDE-1:0] p1c_in;
   logic [WIDE-1:0] p2c_in;

   logic a_valid_ff;
   op_type a_op_ff;
   logic [WIDE-1:0] a_rem_ff;
   logic [WIDE-1:0] a_p1_ff;
   logic [WIDE-1:0] a_p2_ff;
   logic [LW-1:0] a_root_ff;
   logic [WIDE-1:0] a_delta_ff;
   logic [WIDE-1:0] a_p1c_ff;
   logic [WIDE-1:0] a_p2c_ff;

   logic take;
   logic [WIDE-1:0] b_rem_in;
   logic [WIDE-1:0] b_p1_in;
   logic [WIDE-1:0] b_p2_in;
   logic [LW-1:0] b_root_in;

   logic b_valid_ff;
   op_type b_op_ff;
   logic [WIDE-1:0] b_rem_ff;
   logic [WIDE-1:0] b_p1_ff;
   logic [WIDE-1:0] b_p2_ff;
   logic [LW-1:0] b_root_ff;

   assign num_w = WIDE'(shape_num(in_op));

   always_comb begin
      delta_in = (in_p2 << BIT) + (in_p2 << (BIT + 1)) + (in_p1 << (2 * BIT))
               + (in_p1 << (2 * BIT + 1)) + (num_w << (3 * BIT));
      p1c_in = in_p1 + (num_w << BIT);
      p2c_in = in_p2 + (in_p1 << (BIT + 1)) + (num_w << (2 * BIT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
      if (advance) begin
         a_op_ff <= in_op;
         a_rem_ff <= in_rem;
         a_p1_ff <= in_p1;
         a_p2_ff <= in_p2;
         a_root_ff <= in_root;
         a_delta_ff <= delta_in;
         a_p1c_ff <= p1c_in;
         a_p2c_ff <= p2c_in;
      end
   end

   always_comb begin
      take = a_rem_ff >= a_delta_ff;
      b_rem_in = take ? (a_rem_ff - a_delta_ff) : a_rem_ff;
      b_p1_in = take ? a_p1c_ff : a_p1_ff;
      b_p2_in = take ? a_p2c_ff : a_p2_ff;
      b_root_in = a_root_ff | (LW'(take) << BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_op_ff <= a_op_ff;
         b_rem_ff <= b_rem_in;
         b_p1_ff <= b_p1_in;
         b_p2_ff <= b_p2_in;
         b_root_ff <= b_root_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_op = b_op_ff;
   assign out_rem = b_rem_ff;
   assign out_p1 = b_p1_ff;
   assign out_p2 = b_p2_ff;
   assign out_root = b_root_ff;

`ifndef SYNTHESIS
   // Bits below the one decided here must still be clear.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> ((b_root_ff & ((LW'(1) << BIT) - LW'(1))) == '0))
      else $error("root has bits set below the current position");

   // The running products must track the partial root exactly.
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_p1_ff == WIDE'(shape_num(b_op_ff)) * WIDE'(b_root_ff)))
      else $error("num * root product out of step with root");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_p2_ff == WIDE'(shape_num(b_op_ff)) * WIDE'(b_root_ff)
                                 * WIDE'(b_root_ff)))
      else $error("num * root^2 product out of step with root");
`endif

endmodule

// ===== rtl/shape_side_from_volume.sv =====
// Top level of the shape side-from-volume block: exact truncated cube root
// of volume / k through a bit-per-stage pipeline.
// Depends on ssv_pkg, ssv_if and ssv_root_stage.
//
//   channel  direction  fields                   handshake
//   req_ch   in         operation, volume        valid / ready
//   rsp_ch   out        side_length              valid / ready
//
// One transaction is accepted per cycle while the output is not stalled; each gives
// exactly one result. It passes through the register for the volume * den product,
// the trial and update registers of each root bit, and the output register.
// Reset clears only the stage valid bits; the data registers are not reset.
// When the output is held and not taken the whole pipeline stalls in place.
module shape_side_from_volume #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   ssv_req_if.sink req_ch,
   ssv_rsp_if.source rsp_ch
);
   import ssv_pkg::*;

   localparam int LW = INT_BITS + FRAC_BITS;
   localparam int WIDE = 3 * LW + 32;
   localparam int SHIFT = 3 * FRAC_BITS - 16;
   localparam int PROD_W = VOL_W + DEN_W;
   localparam int EXT_W = LW + SIDE_W;

   logic advance;

   logic [PROD_W-1:0] prod_in;
   logic [WIDE-1:0] mul_rem_in;
   logic mul_valid_ff;
   op_type mul_op_ff;
   logic [WIDE-1:0] mul_rem_ff;

   logic ch_valid [LW+1];
   op_type ch_op [LW+1];
   logic [WIDE-1:0] ch_rem [LW+1];
   logic [WIDE-1:0] ch_p1 [LW+1];
   logic [WIDE-1:0] ch_p2 [LW+1];
   logic [LW-1:0] ch_root [LW+1];

   logic [SIDE_W-1:0] side_in;
   logic out_valid_ff;
   logic [SIDE_W-1:0] side_ff;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // The limit volume * den * 2^s; the shift is wiring only.
   always_comb begin
      prod_in = PROD_W'(req_ch.volume) * PROD_W'(shape_den(req_ch.operation));
      mul_rem_in = WIDE'(prod_in) << SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= req_ch.valid;
      end
      if (advance) begin
         mul_op_ff <= req_ch.operation;
         mul_rem_ff <= mul_rem_in;
      end
   end

   assign ch_valid[0] = mul_valid_ff;
   assign ch_op[0] = mul_op_ff;
   assign ch_rem[0] = mul_rem_ff;
   assign ch_p1[0] = '0;
   assign ch_p2[0] = '0;
   assign ch_root[0] = '0;

   for (genvar i = 0; i < LW; i++) begin : g_bit
      ssv_root_stage #(
         .BIT (LW - 1 - i),
         .LW (LW),
         .WIDE (WIDE)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .advance (advance),
         .in_valid (ch_valid[i]),
         .in_op (ch_op[i]),
         .in_rem (ch_rem[i]),
         .in_p1 (ch_p1[i]),
         .in_p2 (ch_p2[i]),
         .in_root (ch_root[i]),
         .out_valid (ch_valid[i+1]),
         .out_op (ch_op[i+1]),
         .out_rem (ch_rem[i+1]),
         .out_p1 (ch_p1[i+1]),
         .out_p2 (ch_p2[i+1]),
         .out_root (ch_root[i+1])
      );
   end

   // Saturate when the root is wider than the output field.
   assign side_in = (EXT_W'(ch_root[LW]) > EXT_W'(SIDE_MAX)) ? SIDE_MAX
                                                            : SIDE_W'(ch_root[LW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ch_valid[LW];
      end
      if (advance) begin
         side_ff <= side_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.side_length = side_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("output valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> mul_valid_ff)
      else $error("accepted transaction did not enter the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mul_valid_ff) && $stable(out_valid_ff)))
      else $error("pipeline moved while stalled");
`endif

endmodule
